// ===== hw/rtl/aes256_block_cipher_unit_defines.svh =====
// Assertion macros used by the cipher unit control RTL.
`ifndef AES256_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES256_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AESBCU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aesbcu: same-cycle check failed");

// Next-cycle implication.
`define AESBCU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aesbcu: next-cycle check failed");

`endif

// ===== hw/rtl/aesbcu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aesbcu_pkg;

   localparam int unsigned MaxRepeatDefault = 255;
   localparam int unsigned RoundKeys        = 15;
   localparam logic [3:0]  RkLast           = 4'd14;
   localparam logic [5:0]  WordFirst        = 6'd8;
   localparam logic [5:0]  WordLast         = 6'd59;

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      REG_KEY_0_7   = 3'd0,
      REG_KEY_8_15  = 3'd1,
      REG_KEY_16_23 = 3'd2,
      REG_KEY_24_31 = 3'd3,
      REG_REPEAT    = 3'd4
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY_LO,
      ST_KEY_HI,
      ST_EXPAND,
      ST_ROUND,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic       key_write_lo;
      logic       key_write_hi;
      logic       exp_step;
      logic [5:0] exp_word;
      logic [3:0] rk_raddr;
      logic       load_block;
      logic       round_en;
      logic [3:0] step;
      logic       decrypt;
      logic       out_load;
   } ctrl_cmd_type;

   localparam logic [7:0] RCON [8] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

endpackage
`default_nettype wire

// ===== hw/rtl/aesbcu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aesbcu_datapath (
   input  wire logic                       clock,
   input  wire aesbcu_pkg::ctrl_cmd_type   cmd,
   input  wire logic [63:0]                key_0_7,
   input  wire logic [63:0]                key_8_15,
   input  wire logic [63:0]                key_16_23,
   input  wire logic [63:0]                key_24_31,
   input  wire logic [63:0]                block_high,
   input  wire logic [63:0]                block_low,
   output logic [63:0]                     result_high,
   output logic [63:0]                     result_low
);

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127 - 8 * i -: 8] =
            aesbcu_pkg::SBOX[byte_of(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4))];
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127 - 8 * i -: 8] =
            aesbcu_pkg::INV_SBOX[byte_of(s, (i % 4) + 4 * (((i / 4) - (i % 4) + 4) % 4))];
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_of(s, 4 * c);
         a1 = byte_of(s, 4 * c + 1);
         a2 = byte_of(s, 4 * c + 2);
         a3 = byte_of(s, 4 * c + 3);
         t[127 - 32 * c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                  a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                  a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                  xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
      end
      return t;
   endfunction

   // Multiples 9, 11, 13 and 14 of one byte, packed as {x9, x11, x13, x14}.
   function automatic logic [31:0] mults(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xt(a);
      x4 = xt(x2);
      x8 = xt(x4);
      return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [31:0]  m0, m1, m2, m3;
      for (int c = 0; c < 4; c++) begin
         m0 = mults(byte_of(s, 4 * c));
         m1 = mults(byte_of(s, 4 * c + 1));
         m2 = mults(byte_of(s, 4 * c + 2));
         m3 = mults(byte_of(s, 4 * c + 3));
         // Fields: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14.
         t[127 - 32 * c -: 32] = {m0[7:0] ^ m1[23:16] ^ m2[15:8] ^ m3[31:24],
                                  m0[31:24] ^ m1[7:0] ^ m2[23:16] ^ m3[15:8],
                                  m0[15:8] ^ m1[31:24] ^ m2[7:0] ^ m3[23:16],
                                  m0[23:16] ^ m1[15:8] ^ m2[31:24] ^ m3[7:0]};
      end
      return t;
   endfunction

   logic [127:0] rk_mem [aesbcu_pkg::RoundKeys];
   logic [127:0] rk_q_ff;
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [31:0]  rot;
   logic [31:0]  new_word;
   logic         rk_we;
   logic [3:0]   rk_waddr;
   logic [127:0] rk_wdata;
   logic [127:0] state_ff;
   logic [127:0] state_in;
   logic [127:0] enc_t;
   logic [127:0] dec_t;
   logic [127:0] out_ff;

   // Next key schedule word from the eight-word window.
   always_comb begin
      rot = win_ff[7];
      if (cmd.exp_word[2:0] == 3'd0) begin
         rot = {aesbcu_pkg::SBOX[win_ff[7][23:16]] ^ aesbcu_pkg::RCON[cmd.exp_word[5:3]],
                aesbcu_pkg::SBOX[win_ff[7][15:8]],
                aesbcu_pkg::SBOX[win_ff[7][7:0]],
                aesbcu_pkg::SBOX[win_ff[7][31:24]]};
      end else if (cmd.exp_word[2:0] == 3'd4) begin
         rot = {aesbcu_pkg::SBOX[win_ff[7][31:24]], aesbcu_pkg::SBOX[win_ff[7][23:16]],
                aesbcu_pkg::SBOX[win_ff[7][15:8]], aesbcu_pkg::SBOX[win_ff[7][7:0]]};
      end
      new_word = win_ff[0] ^ rot;

      win_in = win_ff;
      if (cmd.key_write_lo) begin
         win_in = '{key_0_7[63:32], key_0_7[31:0], key_8_15[63:32], key_8_15[31:0],
                    key_16_23[63:32], key_16_23[31:0], key_24_31[63:32], key_24_31[31:0]};
      end else if (cmd.exp_step) begin
         for (int j = 0; j < 7; j++) begin
            win_in[j] = win_ff[j + 1];
         end
         win_in[7] = new_word;
      end

      rk_we    = 1'b0;
      rk_waddr = 4'd0;
      rk_wdata = {key_0_7, key_8_15};
      if (cmd.key_write_lo) begin
         rk_we = 1'b1;
      end else if (cmd.key_write_hi) begin
         rk_we    = 1'b1;
         rk_waddr = 4'd1;
         rk_wdata = {key_16_23, key_24_31};
      end else if (cmd.exp_step && (cmd.exp_word[1:0] == 2'd3)) begin
         rk_we    = 1'b1;
         rk_waddr = cmd.exp_word[5:2];
         rk_wdata = {win_ff[5], win_ff[6], win_ff[7], new_word};
      end
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[rk_waddr] <= rk_wdata;
      end
      rk_q_ff <= rk_mem[cmd.rk_raddr];
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   // Step zero is the whitening key addition; later steps are rounds, the last one without the column mix.
   always_comb begin
      enc_t = sub_shift(state_ff);
      if (cmd.step != aesbcu_pkg::RkLast) begin
         enc_t = mix(enc_t);
      end
      dec_t = inv_sub_shift(state_ff) ^ rk_q_ff;
      if (cmd.step != aesbcu_pkg::RkLast) begin
         dec_t = inv_mix(dec_t);
      end

      state_in = state_ff;
      if (cmd.load_block) begin
         state_in = {block_high, block_low};
      end else if (cmd.round_en) begin
         if (cmd.step == 4'd0) begin
            state_in = state_ff ^ rk_q_ff;
         end else if (cmd.decrypt) begin
            state_in = dec_t;
         end else begin
            state_in = enc_t ^ rk_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (cmd.out_load) begin
         out_ff <= state_ff;
      end
   end

   assign result_high = out_ff[127:64];
   assign result_low  = out_ff[63:0];

endmodule
`default_nettype wire

// ===== hw/rtl/aesbcu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "aes256_block_cipher_unit_defines.svh"
module aesbcu_ctrl #(
   parameter int unsigned MAX_REPEAT = aesbcu_pkg::MaxRepeatDefault,
   localparam int unsigned PassW     = $clog2(MAX_REPEAT + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     key_written,
   input  wire logic [PassW-1:0]         pass_count,
   input  wire logic                     req_valid,
   input  wire logic                     req_command,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output aesbcu_pkg::ctrl_cmd_type      cmd
);

   aesbcu_pkg::state_type state_ff, state_in;
   logic             dirty_ff, dirty_in;
   logic [3:0]       step_ff, step_in;
   logic [PassW-1:0] pass_ff, pass_in;
   logic [5:0]       word_ff, word_in;
   logic             dec_ff, dec_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aesbcu_pkg::ST_IDLE;
         dirty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      pass_ff <= pass_in;
      word_ff <= word_in;
      dec_ff  <= dec_in;
   end

   always_comb begin
      state_in     = state_ff;
      dirty_in     = dirty_ff | key_written;
      step_in      = step_ff;
      pass_in      = pass_ff;
      word_in      = word_ff;
      dec_in       = dec_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      accept       = 1'b0;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.exp_word = word_ff;
      cmd.step     = step_ff;
      cmd.decrypt  = dec_ff;

      unique case (state_ff)
         aesbcu_pkg::ST_IDLE: begin
            req_stall    = dirty_ff;
            cmd.rk_raddr = (req_command == aesbcu_pkg::CMD_DECRYPT) ? aesbcu_pkg::RkLast : 4'd0;
            if (dirty_ff) begin
               dirty_in = 1'b0;
               state_in = aesbcu_pkg::ST_KEY_LO;
            end else if (req_valid) begin
               accept         = 1'b1;
               cmd.load_block = 1'b1;
               dec_in         = req_command;
               pass_in        = pass_count;
               step_in        = 4'd0;
               state_in       = (pass_count == '0) ? aesbcu_pkg::ST_HOLD : aesbcu_pkg::ST_ROUND;
            end
         end
         aesbcu_pkg::ST_KEY_LO: begin
            cmd.key_write_lo = 1'b1;
            state_in         = aesbcu_pkg::ST_KEY_HI;
         end
         aesbcu_pkg::ST_KEY_HI: begin
            cmd.key_write_hi = 1'b1;
            word_in          = aesbcu_pkg::WordFirst;
            state_in         = aesbcu_pkg::ST_EXPAND;
         end
         aesbcu_pkg::ST_EXPAND: begin
            cmd.exp_step = 1'b1;
            word_in      = 6'(word_ff + 6'd1);
            if (word_ff == aesbcu_pkg::WordLast) begin
               state_in = aesbcu_pkg::ST_IDLE;
            end
         end
         aesbcu_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (step_ff == aesbcu_pkg::RkLast) begin
               step_in      = 4'd0;
               cmd.rk_raddr = dec_ff ? aesbcu_pkg::RkLast : 4'd0;
               if (pass_ff == PassW'(1)) begin
                  state_in = aesbcu_pkg::ST_HOLD;
               end else begin
                  pass_in = PassW'(pass_ff - PassW'(1));
               end
            end else begin
               step_in      = 4'(step_ff + 4'd1);
               cmd.rk_raddr = dec_ff ? 4'(aesbcu_pkg::RkLast - step_in) : step_in;
            end
         end
         aesbcu_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = aesbcu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aesbcu_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `AESBCU_ASSERT_NEXT(a_accept_busy, accept,
      state_ff == aesbcu_pkg::ST_ROUND || state_ff == aesbcu_pkg::ST_HOLD)
   `AESBCU_ASSERT_NOW(a_step_range, state_ff == aesbcu_pkg::ST_ROUND,
      step_ff <= aesbcu_pkg::RkLast && pass_ff != '0)
   `AESBCU_ASSERT_NOW(a_no_accept_dirty, accept, !dirty_ff)
   `AESBCU_ASSERT_NEXT(a_out_load, cmd.out_load, rsp_valid_ff)

endmodule
`default_nettype wire

// ===== hw/rtl/aes256_block_cipher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted block goes through N cipher passes, N the repeat count capped at MAX_REPEAT.
// One shared round unit does one round per cycle; the next block waits for the last result.
// A key register write starts a key expansion once idle; no block is taken until it ends.
// Reset (synchronous, active high) clears the key to zero, sets repeat count to one
// and starts a key expansion for the all-zero key; no block is accepted until it ends.
module aes256_block_cipher_unit #(
   parameter int unsigned MAX_REPEAT = aesbcu_pkg::MaxRepeatDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [63:0] rsp_result_high,
   output logic      [63:0] rsp_result_low
);

   localparam int unsigned PassW = $clog2(MAX_REPEAT + 1);

   aesbcu_pkg::ctrl_cmd_type   cmd;
   aesbcu_pkg::reg_idx_type    reg_idx;
   logic [63:0]      key_ff [4];
   logic [7:0]       repeat_ff;
   logic             wr_en;
   logic             key_written;
   logic [PassW-1:0] pass_count;

   assign csr_pready = 1'b1;
   assign reg_idx    = aesbcu_pkg::reg_idx_type'(csr_paddr[5:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '{64'd0, 64'd0, 64'd0, 64'd0};
         repeat_ff <= 8'd1;
      end else if (wr_en) begin
         unique case (reg_idx)
            aesbcu_pkg::REG_KEY_0_7,
            aesbcu_pkg::REG_KEY_8_15,
            aesbcu_pkg::REG_KEY_16_23,
            aesbcu_pkg::REG_KEY_24_31: key_ff[csr_paddr[4:3]] <= csr_pwdata;
            aesbcu_pkg::REG_REPEAT:    repeat_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      key_written = 1'b0;
      csr_prdata  = 64'd0;
      unique case (reg_idx)
         aesbcu_pkg::REG_KEY_0_7,
         aesbcu_pkg::REG_KEY_8_15,
         aesbcu_pkg::REG_KEY_16_23,
         aesbcu_pkg::REG_KEY_24_31: begin
            key_written = wr_en;
            csr_prdata  = key_ff[csr_paddr[4:3]];
         end
         aesbcu_pkg::REG_REPEAT: csr_prdata = {56'd0, repeat_ff};
         default: ;
      endcase
   end

   // A count above the cap saturates.
   always_comb begin
      if (32'(repeat_ff) > 32'(MAX_REPEAT)) begin
         pass_count = PassW'(MAX_REPEAT);
      end else begin
         pass_count = PassW'(repeat_ff);
      end
   end

   aesbcu_ctrl #(
      .MAX_REPEAT (MAX_REPEAT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .key_written (key_written),
      .pass_count  (pass_count),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   aesbcu_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .key_0_7     (key_ff[0]),
      .key_8_15    (key_ff[1]),
      .key_16_23   (key_ff[2]),
      .key_24_31   (key_ff[3]),
      .block_high  (req_block_high),
      .block_low   (req_block_low),
      .result_high (rsp_result_high),
      .result_low  (rsp_result_low)
   );

endmodule
`default_nettype wire

// ===== dv/aes256_block_cipher_unit_test.sv =====
`timescale 1ns / 1ps
module aes256_block_cipher_unit_test;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int TAIL_CYCLES = 4000;
   localparam logic [2:0] REG_UNUSED = 3'd5;

   typedef struct {
      bit          cfg;
      logic [63:0] k0, k1, k2, k3;
      logic [7:0]  reps;
      aesbcu_pkg::command_type cmd;
      logic [63:0] hi, lo;
      bit          typed;
      logic [63:0] eh, el;
   } row_type;

   localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] F0 = 64'h0001020304050607, F1 = 64'h08090a0b0c0d0e0f;
   localparam logic [63:0] F2 = 64'h1011121314151617, F3 = 64'h18191a1b1c1d1e1f;

   // The first rows run on the reset key and count, before any register write.
   row_type dir_rows [14] = '{
      '{0, 0, 0, 0, 0, 1, aesbcu_pkg::CMD_ENCRYPT, 0, 0, 1,
        64'hdc95c078a2408989, 64'had48a21492842087},
      '{0, 0, 0, 0, 0, 1, aesbcu_pkg::CMD_ENCRYPT, ONES, ONES, 0, 0, 0},
      '{0, 0, 0, 0, 0, 1, aesbcu_pkg::CMD_DECRYPT, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 1, aesbcu_pkg::CMD_DECRYPT, 64'hdc95c078a2408989,
        64'had48a21492842087, 1, 0, 0},
      '{0, 0, 0, 0, 0, 1, aesbcu_pkg::CMD_DECRYPT, ONES, ONES, 0, 0, 0},
      '{1, F0, F1, F2, F3, 1, aesbcu_pkg::CMD_ENCRYPT, 64'h0011223344556677,
        64'h8899aabbccddeeff, 1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
      '{0, 0, 0, 0, 0, 1, aesbcu_pkg::CMD_DECRYPT, 64'h8ea2b7ca516745bf,
        64'heafc49904b496089, 1, 64'h0011223344556677, 64'h8899aabbccddeeff},
      '{1, F0, F1, F2, F3, 0, aesbcu_pkg::CMD_ENCRYPT, 64'h0123456789abcdef,
        64'hfedcba9876543210, 1, 64'h0123456789abcdef, 64'hfedcba9876543210},
      '{0, 0, 0, 0, 0, 0, aesbcu_pkg::CMD_DECRYPT, ONES, 0, 1, ONES, 0},
      '{1, ONES, ONES, ONES, ONES, 2, aesbcu_pkg::CMD_ENCRYPT, ONES, ONES, 0, 0, 0},
      '{0, 0, 0, 0, 0, 2, aesbcu_pkg::CMD_DECRYPT, 0, ONES, 0, 0, 0},
      '{1, ONES, 0, ONES, 0, 255, aesbcu_pkg::CMD_ENCRYPT, 64'h0011223344556677, 0,
        0, 0, 0},
      '{0, 0, 0, 0, 0, 255, aesbcu_pkg::CMD_DECRYPT, ONES, 64'h8899aabbccddeeff,
        0, 0, 0},
      '{1, F0, F1, F2, F3, 1, aesbcu_pkg::CMD_ENCRYPT, 64'h8000000000000001, 64'h1,
        0, 0, 0}
   };

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [5:0]  csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_command = 0;
   logic [63:0] req_block_high = 0, req_block_low = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_result_high, rsp_result_low;

   aes256_block_cipher_unit DUT (.*);

   always #10 clock = ~clock;

   // Mirror of the block's configuration and expanded round keys.
   logic [63:0]  key_mirror [4];
   logic [7:0]   repeat_mirror;
   logic [127:0] round_keys [15];
   logic [127:0] pending_results [$];
   int           errors = 0, cycles = 0, blocks_out = 0, enc_sent = 0, dec_sent = 0;
   int           max_reps_seen = 0;
   bit           quiet = 0;

   function automatic logic [7:0] xt(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 0;
      while (b != 0) begin
         if (b[0]) p ^= a;
         a = xt(a);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] w [60];
      logic [31:0] t;
      for (int i = 0; i < 8; i++)
         w[i] = i[0] ? key_mirror[i >> 1][31:0] : key_mirror[i >> 1][63:32];
      for (int i = 8; i < 60; i++) begin
         t = w[i - 1];
         if (i % 8 == 0)
            t = {aesbcu_pkg::SBOX[t[23:16]] ^ aesbcu_pkg::RCON[(i >> 3) & 7],
                 aesbcu_pkg::SBOX[t[15:8]], aesbcu_pkg::SBOX[t[7:0]],
                 aesbcu_pkg::SBOX[t[31:24]]};
         else if (i % 8 == 4)
            t = {aesbcu_pkg::SBOX[t[31:24]], aesbcu_pkg::SBOX[t[23:16]],
                 aesbcu_pkg::SBOX[t[15:8]], aesbcu_pkg::SBOX[t[7:0]]};
         w[i] = w[i - 8] ^ t;
      end
      for (int r = 0; r < 15; r++)
         round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   function automatic logic [127:0] aes_pass(logic [127:0] x, logic decrypt);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      int row, col;
      for (int i = 0; i < 16; i++) s[i] = x[127 - 8*i -: 8];
      if (!decrypt) begin
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][127 - 8*i -: 8];
         for (int r = 1; r <= 14; r++) begin
            for (int i = 0; i < 16; i++) begin
               row = i & 3; col = i >> 2;
               t[i] = aesbcu_pkg::SBOX[s[row + 4 * ((col + row) & 3)]];
            end
            s = t;
            if (r != 14)
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  s[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                  s[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                  s[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                  s[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
               end
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127 - 8*i -: 8];
         end
      end else begin
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[14][127 - 8*i -: 8];
         for (int r = 13; r >= 0; r--) begin
            for (int i = 0; i < 16; i++) begin
               row = i & 3; col = i >> 2;
               t[i] = aesbcu_pkg::INV_SBOX[s[row + 4 * ((col - row + 4) & 3)]];
            end
            s = t;
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127 - 8*i -: 8];
            if (r != 0)
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  s[4*c]   = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
                  s[4*c+1] = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
                  s[4*c+2] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
                  s[4*c+3] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
               end
         end
      end
      for (int i = 0; i < 16; i++) x[127 - 8*i -: 8] = s[i];
      return x;
   endfunction

   function automatic logic [127:0] cipher_block(logic [127:0] x, logic decrypt);
      int n;
      n = (repeat_mirror > aesbcu_pkg::MaxRepeatDefault) ?
          aesbcu_pkg::MaxRepeatDefault : repeat_mirror;
      for (int k = 0; k < n; k++) x = aes_pass(x, decrypt);
      return x;
   endfunction

   task automatic reg_write(logic [2:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx <= aesbcu_pkg::REG_KEY_24_31) begin
         key_mirror[idx] = data;
         expand_round_keys();
      end else if (idx == aesbcu_pkg::REG_REPEAT) begin
         repeat_mirror = data[7:0];
      end
   endtask

   task automatic write_settings(logic [63:0] k0, k1, k2, k3, logic [7:0] reps);
      reg_write(aesbcu_pkg::REG_KEY_0_7, k0);
      reg_write(aesbcu_pkg::REG_KEY_8_15, k1);
      reg_write(aesbcu_pkg::REG_KEY_16_23, k2);
      reg_write(aesbcu_pkg::REG_KEY_24_31, k3);
      // Upper bits of the count register must be dropped.
      reg_write(aesbcu_pkg::REG_REPEAT,
                ({$urandom, $urandom} & 64'hffff_ffff_ffff_ff00) | {56'd0, reps});
      reg_write(REG_UNUSED, {$urandom, $urandom});
      if (reps > max_reps_seen) max_reps_seen = reps;
   endtask

   task automatic wait_all_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_block(aesbcu_pkg::command_type cmd, logic [63:0] hi, logic [63:0] lo,
                             bit typed, logic [127:0] typed_result);
      if (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_block_high <= hi;
      req_block_low <= lo;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(typed ? typed_result : cipher_block({hi, lo}, cmd));
      if (cmd == aesbcu_pkg::CMD_DECRYPT) dec_sent++; else enc_sent++;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(7))
         0: return 64'h0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 26);
      if (!reset && rsp_valid && !rsp_stall) begin
         blocks_out++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h_%h", $time, rsp_result_high, rsp_result_low);
            errors++;
         end else begin
            if (rsp_result_high !== pending_results[0][127:64]) begin
               $display("%0t: result_high expected %h actual %h", $time,
                        pending_results[0][127:64], rsp_result_high);
               errors++;
            end
            if (rsp_result_low !== pending_results[0][63:0]) begin
               $display("%0t: result_low expected %h actual %h", $time,
                        pending_results[0][63:0], rsp_result_low);
               errors++;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int reps, count;
      for (int i = 0; i < 4; i++) key_mirror[i] = 0;
      repeat_mirror = 1;
      expand_round_keys();
      repeat (8) @(posedge clock);
      reset <= 0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cfg) begin
            req_valid <= 0;
            wait_all_results();
            write_settings(dir_rows[i].k0, dir_rows[i].k1, dir_rows[i].k2, dir_rows[i].k3,
                           dir_rows[i].reps);
         end
         send_block(dir_rows[i].cmd, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].typed,
                    {dir_rows[i].eh, dir_rows[i].el});
      end

      // Most phases use short counts; a few take the longest count.
      for (int phase = 0; phase < 27; phase++) begin
         req_valid <= 0;
         wait_all_results();
         case (phase % 6)
            0: reps = 0;
            1, 2: reps = 1;
            3: reps = $urandom_range(2, 3);
            4: reps = $urandom_range(4, 12);
            default: reps = (phase % 12 == 11) ? 255 : $urandom_range(1, 2);
         endcase
         write_settings(rand_word(), rand_word(), rand_word(), rand_word(), reps);
         count = (reps > 100) ? 3 : (reps > 3 ? 20 : 60);
         quiet = (phase == 7 || phase == 8);
         for (int n = 0; n < count; n++) begin
            send_block(aesbcu_pkg::command_type'($urandom_range(1)), rand_word(),
                       rand_word(), 0, 0);
            // A mid-phase pause lets the unit empty completely.
            if (n == count / 2 && phase % 4 == 1) begin
               req_valid <= 0;
               wait_all_results();
            end
         end
      end
      quiet = 0;
      req_valid <= 0;
      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d encrypt and %0d decrypt blocks, got %0d results, counts up to %0d.",
               enc_sent, dec_sent, blocks_out, max_reps_seen);
      if (errors == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/aesbcu_pkg.sv
hw/rtl/aesbcu_datapath.sv
hw/rtl/aesbcu_ctrl.sv
hw/rtl/aes256_block_cipher_unit.sv
dv/aes256_block_cipher_unit_test.sv
